// ----- rtl/emulated_memory_access_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the emulated memory access decoder
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef EMULATED_MEMORY_ACCESS_DECODER_CORE_DEFINES_SVH
`define EMULATED_MEMORY_ACCESS_DECODER_CORE_DEFINES_SVH

// Property checked only while the block is out of reset.
`define EMAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define EMAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/emad_pkg.sv -----
// ----------------------------------------------------------------------------
// emad_pkg
// Types and constants shared by the memory access decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package emad_pkg;

    localparam int MAIN_MEM_BYTES = 1048576;
    localparam int PALETTE_BYTES  = 512;
    localparam int MAIN_AW        = $clog2(MAIN_MEM_BYTES);
    localparam int PAL_AW         = $clog2(PALETTE_BYTES);

    // Address map of the checked windows.
    localparam logic [23:0] PAL_BASE      = 24'hE82000;
    localparam logic [23:0] PAL_END       = 24'hE82200;
    localparam logic [23:0] REG_WIN_END   = 24'hE82400;
    localparam logic [23:0] SINGLE_REG    = 24'hE82500;
    localparam logic [23:0] SPR_RD_BASE   = 24'hEB8000;
    localparam logic [23:0] SPR_END       = 24'hEBC000;
    localparam logic [23:0] IO_BASE       = 24'hC00000;
    localparam logic [23:0] GVRAM_WR_BASE = 24'hD00000;
    localparam logic [23:0] GVRAM_WR_END  = 24'hD80000;
    localparam logic [23:0] SPR_WR_BASE   = 24'hEB0000;
    localparam logic [23:0] SPR_REG_END   = 24'hEB0400;
    localparam logic [23:0] ADDR_MASK     = 24'hFFFFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENV_TOP   = 2'd0;
    localparam logic [1:0] CFG_MEM_TOP   = 2'd1;
    localparam logic [1:0] CFG_IO_IGNORE = 2'd2;

    localparam logic [23:0] MEM_TOP_RESET = 24'h100000;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2
    } size_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_IGNORED   = 2'd1,
        STS_IO_FAULT  = 2'd2,
        STS_BAD_ADDR  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ACCESS,
        ST_COLLECT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/emulated_memory_access_decoder_core.sv -----
// ----------------------------------------------------------------------------
// emulated_memory_access_decoder_core
// Byte-serial memory access unit with address checking for an emulated CPU.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_ channel; one transfer carries one read or write
// of a byte, word or long. The answer leaves on the m_ channel as one
// transfer with the big-endian read value and a status code.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets env_top,
// mem_top and io_ignore; the user must write it only while no request is
// in flight, and the block itself does not enforce this. The check comes
// first, then each byte of the access goes through the shared byte port of
// the memories: a write issues the byte, a read issues it and then collects
// the registered read data. An ignored or faulted access skips the bytes.
// One request is handled at a time; s_tready rises again in the cycle after
// the result transfer, so no new request is taken before the last result
// has gone. After reset a clearing pass zeroes the 512-byte palette, one
// byte per cycle, and s_tready stays low until it ends; configuration
// writes are taken during that pass. When the receiver stalls, the
// result is held unchanged on m_tdata and m_tuser until m_tready is seen
// high.
// ----------------------------------------------------------------------------
`default_nettype none

module emulated_memory_access_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: address[23:0], access_size[25:24], write_data[57:26], zero[63:58]
    input  wire logic [63:0] s_tdata,
    // s_tuser: req_type[0], supervisor[1]
    input  wire logic [1:0]  s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: read_data[31:0]
    output logic      [31:0] m_tdata,
    // m_tuser: status[1:0]
    output logic      [1:0]  m_tuser,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    localparam int MAIN_AW = emad_pkg::MAIN_AW;
    localparam int PAL_AW  = emad_pkg::PAL_AW;
    localparam logic [23:0] MAIN_TOP = 24'(emad_pkg::MAIN_MEM_BYTES);

    // Configuration registers.
    logic [23:0] env_top_reg;
    logic [23:0] mem_top_reg;
    logic        io_ignore_reg;

    // Sequencer and request registers.
    emad_pkg::state_t  state_reg, state_next;
    emad_pkg::status_t status_reg, status_next;
    logic              is_write_reg, is_write_next;
    logic              sup_reg, sup_next;
    logic [23:0]       addr_reg, addr_next;
    logic [1:0]        last_reg, last_next;
    logic [1:0]        k_reg, k_next;
    logic [31:0]       wsh_reg, wsh_next;
    logic [31:0]       rd_reg, rd_next;
    logic              pal_reg, pal_next;
    logic              hit_reg, hit_next;
    logic [PAL_AW-1:0] clr_reg, clr_next;

    // Byte port signals.
    logic [24:0]        byte_addr;
    logic               in_main;
    logic [PAL_AW-1:0]  pal_index;
    logic               pal_we;
    logic [PAL_AW-1:0]  pal_addr;
    logic [7:0]         pal_wdata;
    logic [7:0]         pal_rdata;
    logic               main_we;
    logic [7:0]         main_rdata;
    logic [7:0]         rd_byte;

    // Address check.
    logic [23:0]        top;
    logic               checked;
    logic               in_pal;
    logic               ignored;
    emad_pkg::status_t  check_status;

    logic [31:0] in_wdata;
    logic [1:0]  in_size;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_top_reg   <= '0;
            mem_top_reg   <= emad_pkg::MEM_TOP_RESET;
            io_ignore_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                emad_pkg::CFG_ENV_TOP:   env_top_reg   <= cfg_wdata & emad_pkg::ADDR_MASK;
                emad_pkg::CFG_MEM_TOP:   mem_top_reg   <= cfg_wdata & emad_pkg::ADDR_MASK;
                emad_pkg::CFG_IO_IGNORE: io_ignore_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Address classification of the registered request. Only addresses
    // below env_top or at or above the top of memory are checked; the top
    // of memory never exceeds the physical store.
    // ------------------------------------------------------------------
    always_comb begin
        top     = (mem_top_reg < MAIN_TOP) ? mem_top_reg : MAIN_TOP;
        checked = (addr_reg < env_top_reg) || (addr_reg >= top);
        in_pal  = (addr_reg >= emad_pkg::PAL_BASE) && (addr_reg < emad_pkg::PAL_END);
        if (is_write_reg) begin
            ignored = ((addr_reg >= emad_pkg::GVRAM_WR_BASE) &&
                       (addr_reg < emad_pkg::GVRAM_WR_END)) ||
                      ((addr_reg >= emad_pkg::SPR_WR_BASE) &&
                       (addr_reg < emad_pkg::SPR_END)) ||
                      ((addr_reg >= emad_pkg::PAL_END) &&
                       (addr_reg < emad_pkg::REG_WIN_END)) ||
                      (addr_reg == emad_pkg::SINGLE_REG);
        end else begin
            ignored = ((addr_reg >= emad_pkg::PAL_END) &&
                       (addr_reg < emad_pkg::REG_WIN_END)) ||
                      ((addr_reg >= emad_pkg::SPR_RD_BASE) &&
                       (addr_reg < emad_pkg::SPR_END)) ||
                      (addr_reg == emad_pkg::SINGLE_REG);
        end

        if (!checked || in_pal) begin
            check_status = emad_pkg::STS_DONE;
        end else if (ignored) begin
            check_status = emad_pkg::STS_IGNORED;
        end else if (addr_reg >= emad_pkg::IO_BASE) begin
            check_status = io_ignore_reg ? emad_pkg::STS_IGNORED : emad_pkg::STS_IO_FAULT;
        end else if (!sup_reg || (addr_reg >= top)) begin
            check_status = emad_pkg::STS_BAD_ADDR;
        end else begin
            check_status = emad_pkg::STS_DONE;
        end
    end

    // ------------------------------------------------------------------
    // Byte port: byte k of the access. Palette bytes wrap inside the
    // window; main memory bytes past the store read zero and drop writes.
    // ------------------------------------------------------------------
    assign byte_addr = {1'b0, addr_reg} + 25'(k_reg);
    assign in_main   = byte_addr < 25'(emad_pkg::MAIN_MEM_BYTES);
    assign pal_index = addr_reg[PAL_AW-1:0] + PAL_AW'(k_reg);

    always_comb begin
        if (state_reg == emad_pkg::ST_CLEAR) begin
            pal_we    = 1'b1;
            pal_addr  = clr_reg;
            pal_wdata = 8'h00;
        end else begin
            pal_we    = (state_reg == emad_pkg::ST_ACCESS) && is_write_reg && pal_reg;
            pal_addr  = pal_index;
            pal_wdata = wsh_reg[31:24];
        end
    end

    assign main_we = (state_reg == emad_pkg::ST_ACCESS) && is_write_reg && !pal_reg && in_main;

    emad_ram #(
        .WIDTH (8),
        .DEPTH (emad_pkg::PALETTE_BYTES)
    ) u_pal_ram (
        .clk   (aclk),
        .we    (pal_we),
        .addr  (pal_addr),
        .wdata (pal_wdata),
        .rdata (pal_rdata)
    );

    emad_ram #(
        .WIDTH (8),
        .DEPTH (emad_pkg::MAIN_MEM_BYTES)
    ) u_main_ram (
        .clk   (aclk),
        .we    (main_we),
        .addr  (byte_addr[MAIN_AW-1:0]),
        .wdata (wsh_reg[31:24]),
        .rdata (main_rdata)
    );

    assign rd_byte = !hit_reg ? 8'h00 : (pal_reg ? pal_rdata : main_rdata);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emad_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        is_write_reg <= is_write_next;
        sup_reg      <= sup_next;
        addr_reg     <= addr_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        wsh_reg      <= wsh_next;
        rd_reg       <= rd_next;
        pal_reg      <= pal_next;
        hit_reg      <= hit_next;
    end

    assign in_wdata = s_tdata[57:26];
    assign in_size  = s_tdata[25:24];

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        status_next   = status_reg;
        is_write_next = is_write_reg;
        sup_next      = sup_reg;
        addr_next     = addr_reg;
        last_next     = last_reg;
        k_next        = k_reg;
        wsh_next      = wsh_reg;
        rd_next       = rd_reg;
        pal_next      = pal_reg;
        hit_next      = hit_reg;

        case (state_reg)
            emad_pkg::ST_CLEAR: begin
                clr_next = clr_reg + PAL_AW'(1);
                if (clr_reg == PAL_AW'(emad_pkg::PALETTE_BYTES - 1)) begin
                    state_next = emad_pkg::ST_IDLE;
                end
            end
            emad_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    is_write_next = s_tuser[0];
                    sup_next      = s_tuser[1];
                    addr_next     = s_tdata[23:0];
                    k_next        = 2'd0;
                    // Align the write data so its first byte sits on top.
                    case (in_size)
                        emad_pkg::SIZE_BYTE: begin
                            last_next = 2'd0;
                            wsh_next  = {in_wdata[7:0], 24'h000000};
                        end
                        emad_pkg::SIZE_WORD: begin
                            last_next = 2'd1;
                            wsh_next  = {in_wdata[15:0], 16'h0000};
                        end
                        default: begin
                            last_next = 2'd3;
                            wsh_next  = in_wdata;
                        end
                    endcase
                    state_next = emad_pkg::ST_CHECK;
                end
            end
            emad_pkg::ST_CHECK: begin
                status_next = check_status;
                pal_next    = in_pal;
                rd_next     = '0;
                if (check_status == emad_pkg::STS_DONE) begin
                    state_next = emad_pkg::ST_ACCESS;
                end else begin
                    state_next = emad_pkg::ST_DONE;
                end
            end
            emad_pkg::ST_ACCESS: begin
                hit_next = pal_reg || in_main;
                if (is_write_reg) begin
                    wsh_next = {wsh_reg[23:0], 8'h00};
                    if (k_reg == last_reg) begin
                        state_next = emad_pkg::ST_DONE;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else begin
                    state_next = emad_pkg::ST_COLLECT;
                end
            end
            emad_pkg::ST_COLLECT: begin
                rd_next = {rd_reg[23:0], rd_byte};
                if (k_reg == last_reg) begin
                    state_next = emad_pkg::ST_DONE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = emad_pkg::ST_ACCESS;
                end
            end
            emad_pkg::ST_DONE: begin
                if (m_tready) begin
                    state_next = emad_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = emad_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == emad_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == emad_pkg::ST_DONE);
    assign m_tdata  = rd_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

// ----- rtl/emad_ram.sv -----
// ----------------------------------------------------------------------------
// emad_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module emad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/emad_checker.sv -----
// ----------------------------------------------------------------------------
// emad_checker
// Port-level assertions for the memory access decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "emulated_memory_access_decoder_core_defines.svh"

module emad_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_we,
    input wire logic [1:0]  cfg_index,
    input wire logic [23:0] cfg_wdata
);

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, cfg_we, cfg_index, cfg_wdata};

    // A result is never offered in the cycle after reset.
    `EMAD_ASSERT_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result after reset")

    // Only one request is in flight: no new request while a result waits.
    `EMAD_ASSERT(a_one_in_flight, aclk, aresetn, !(s_tready && m_tvalid), "ready while result pending")

    // An accepted request closes the input until its result has gone.
    `EMAD_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")

    // Ignored or faulted accesses return zero data.
    `EMAD_ASSERT(a_zero_on_reject, aclk, aresetn, (m_tvalid && (m_tuser != emad_pkg::STS_DONE)) |-> (m_tdata == 32'h0), "nonzero data on rejected access")

    // A stalled result holds its data.
    `EMAD_ASSERT(a_hold_on_stall, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

endmodule

bind emulated_memory_access_decoder_core emad_checker u_emad_checker (.*);

`default_nettype wire
